// File: rtl/core/occ_pkg.sv
// Shared types, register indexes and helpers for the one's complement checksum block.
`timescale 1ns / 1ps
`default_nettype none

package occ_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PSEUDO_ENABLE     = 3'd0,
        CFG_SRC_ADDR          = 3'd1,
        CFG_DST_ADDR          = 3'd2,
        CFG_PROTOCOL_NUMBER   = 3'd3,
        CFG_COMPLEMENT_RESULT = 3'd4,
        CFG_START_ODD         = 3'd5,
        CFG_INITIAL_SUM       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic        pseudo_enable;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [7:0]  protocol_number;
        logic        complement_result;
        logic        start_odd;
        logic [31:0] initial_sum;
    } t_cfg;

    typedef struct packed {
        logic        pseudo_enable;
        logic        start_odd;
        logic [31:0] initial_sum;
    } t_start;

    typedef struct packed {
        logic [31:0] sum;
        logic [15:0] count;
        logic        pseudo;
    } t_rec;

    function automatic logic [16:0] addr_words(input logic [31:0] addr);
        logic [15:0] w0;
        logic [15:0] w1;
        w0 = {addr[23:16], addr[31:24]};
        w1 = {addr[7:0], addr[15:8]};
        return {1'b0, w0} + {1'b0, w1};
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/occ_cfg.sv
// Configuration register file with same-cycle bypass of the packet start values.
`timescale 1ns / 1ps
`default_nettype none

module occ_cfg (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [occ_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [occ_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output occ_pkg::t_cfg                           o_cfg,
    output occ_pkg::t_start                         o_start
);

    occ_pkg::t_cfg r_cfg;
    occ_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (occ_pkg::t_cfg_idx'(i_cfg_index))
                occ_pkg::CFG_PSEUDO_ENABLE:     n_cfg.pseudo_enable     = i_cfg_data[0];
                occ_pkg::CFG_SRC_ADDR:          n_cfg.src_addr          = i_cfg_data;
                occ_pkg::CFG_DST_ADDR:          n_cfg.dst_addr          = i_cfg_data;
                occ_pkg::CFG_PROTOCOL_NUMBER:   n_cfg.protocol_number   = i_cfg_data[7:0];
                occ_pkg::CFG_COMPLEMENT_RESULT: n_cfg.complement_result = i_cfg_data[0];
                occ_pkg::CFG_START_ODD:         n_cfg.start_odd         = i_cfg_data[0];
                occ_pkg::CFG_INITIAL_SUM:       n_cfg.initial_sum       = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{complement_result: 1'b1, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg                 = r_cfg;
    assign o_start.pseudo_enable = n_cfg.pseudo_enable;
    assign o_start.start_odd     = n_cfg.start_odd;
    assign o_start.initial_sum   = n_cfg.initial_sum;

endmodule

`default_nettype wire

// File: rtl/core/occ_front.sv
// Front end: accept bytes, accumulate the lane sum and count, queue a record per packet.
`timescale 1ns / 1ps
`default_nettype none

module occ_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data_byte,
    input  wire logic           i_last,
    output logic                o_stall,
    input  wire occ_pkg::t_start i_start,
    input  wire logic           i_q_full,
    output logic                o_push,
    output occ_pkg::t_rec       o_rec
);

    logic        r_active;
    logic        r_pseudo;
    logic        r_lane;
    logic [31:0] r_sum;
    logic [15:0] r_count;

    logic        take;
    logic        pm;
    logic        lane;
    logic [31:0] base;
    logic [15:0] cnt;
    logic [31:0] addend;
    logic [32:0] raw;
    logic [31:0] n_sum;
    logic [15:0] n_count;

    assign o_stall = i_q_full;
    assign take    = i_valid && !i_q_full;

    always_comb begin
        if (!r_active) begin
            pm   = i_start.pseudo_enable;
            lane = i_start.pseudo_enable ? 1'b0 : i_start.start_odd;
            base = i_start.pseudo_enable ? 32'd0 : i_start.initial_sum;
            cnt  = 16'd0;
        end else begin
            pm   = r_pseudo;
            lane = r_lane;
            base = r_sum;
            cnt  = r_count;
        end
        addend  = lane ? {16'd0, i_data_byte, 8'd0} : {24'd0, i_data_byte};
        raw     = {1'b0, base} + {1'b0, addend};
        n_sum   = raw[31:0] + {31'd0, raw[32]};
        n_count = cnt + 16'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (take) begin
            r_active <= !i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pseudo <= pm;
            r_lane   <= !lane;
            r_sum    <= n_sum;
            r_count  <= n_count;
        end
    end

    assign o_push       = take && i_last;
    assign o_rec.sum    = n_sum;
    assign o_rec.count  = n_count;
    assign o_rec.pseudo = pm;

endmodule

`default_nettype wire

// File: rtl/core/occ_queue.sv
// Short request queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module occ_queue #(
    parameter int DEPTH = occ_pkg::QUEUE_DEPTH
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire occ_pkg::t_rec i_rec,
    output logic            o_full,
    input  wire logic       i_pop,
    output logic            o_valid,
    output occ_pkg::t_rec   o_rec
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    occ_pkg::t_rec   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/occ_back.sv
// Back end: add the pseudo-header, fold the carries, optionally complement and register the result.
`timescale 1ns / 1ps
`default_nettype none

module occ_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire occ_pkg::t_cfg  i_cfg,
    input  wire logic           i_q_valid,
    input  wire occ_pkg::t_rec  i_rec,
    output logic                o_pop,
    output logic                o_valid,
    output logic [15:0]         o_checksum,
    input  wire logic           i_stall
);

    logic        r_v1;
    logic [16:0] r_p1;
    logic [18:0] r_h1;
    logic        r_inv1;
    logic        r_v2;
    logic [19:0] r_y2;
    logic        r_inv2;
    logic        r_vo;
    logic [15:0] r_out;

    logic        can_o;
    logic        can2;
    logic        can1;
    logic [16:0] p;
    logic [18:0] h;
    logic [15:0] len_sw;
    logic [16:0] z;
    logic [15:0] f;

    assign can_o = !r_vo || !i_stall;
    assign can2  = !r_v2 || can_o;
    assign can1  = !r_v1 || can2;
    assign o_pop = i_q_valid && can1;

    always_comb begin
        len_sw = {i_rec.count[7:0], i_rec.count[15:8]};
        p      = {1'b0, i_rec.sum[31:16]} + {1'b0, i_rec.sum[15:0]};
        if (i_rec.pseudo) begin
            h = 19'(occ_pkg::addr_words(i_cfg.src_addr))
              + 19'(occ_pkg::addr_words(i_cfg.dst_addr))
              + {3'd0, i_cfg.protocol_number, 8'd0}
              + {3'd0, len_sw};
        end else begin
            h = '0;
        end
        z = {13'd0, r_y2[19:16]} + {1'b0, r_y2[15:0]};
        f = z[15:0] + {15'd0, z[16]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (can1) begin
                r_v1 <= i_q_valid;
            end
            if (can2) begin
                r_v2 <= r_v1;
            end
            if (can_o) begin
                r_vo <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can1) begin
            r_p1   <= p;
            r_h1   <= h;
            r_inv1 <= i_rec.pseudo || i_cfg.complement_result;
        end
        if (can2) begin
            r_y2   <= {3'd0, r_p1} + {1'b0, r_h1};
            r_inv2 <= r_inv1;
        end
        if (can_o) begin
            r_out <= r_inv2 ? ~f : f;
        end
    end

    assign o_valid    = r_vo;
    assign o_checksum = r_out;

endmodule

`default_nettype wire

// File: rtl/core/ones_complement_checksum_pseudo_header.sv
// Top level of the one's complement checksum block with IPv4 pseudo-header.
//
// Input channel: one byte per request on i_data_byte with i_last marking the
// final byte of a packet; a request is taken when i_valid is high and o_stall
// is low. Output channel: one checksum per packet on o_checksum, taken when
// o_valid is high and i_stall is low. Registers are written through i_cfg_we,
// i_cfg_index and i_cfg_data; a start value written in the same cycle as the
// first byte of a packet applies to that packet.
// Throughput: one byte per cycle while o_stall is low, and one packet per cycle
// for one-byte packets. A checksum passes through the queue and then the three
// back-end stages (pseudo-header sum, merge, fold) before it reaches o_checksum.
// A four-entry queue parts the byte accumulator from the back end; o_stall is
// high only while that queue is full.
// When i_stall holds, the result register keeps its value and the back end
// fills up, then the queue, then o_stall rises.
// Reset clears all control state and any packet in progress; registers return
// to their reset values (complement on, all others zero).
`timescale 1ns / 1ps
`default_nettype none

module ones_complement_checksum_pseudo_header #(
    parameter int QUEUE_DEPTH = occ_pkg::QUEUE_DEPTH
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [7:0]                         i_data_byte,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [15:0]                             o_checksum,
    input  wire logic                               i_cfg_we,
    input  wire logic [occ_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  wire logic [occ_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    occ_pkg::t_cfg   cfg;
    occ_pkg::t_start start;
    occ_pkg::t_rec   push_rec;
    occ_pkg::t_rec   pop_rec;
    logic            q_full;
    logic            push;
    logic            pop;
    logic            q_valid;

    occ_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_start     (start)
    );

    occ_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_stall     (o_stall),
        .i_start     (start),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    occ_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (pop_rec)
    );

    occ_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_q_valid  (q_valid),
        .i_rec      (pop_rec),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_checksum (o_checksum),
        .i_stall    (i_stall)
    );

endmodule

`default_nettype wire

// File: rtl/core/occ_chk.sv
// Port-level checker for the checksum block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module occ_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_checksum
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_checksum))
        else $error("stalled result changed or dropped");

    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n ##1 1'b1 |=> !o_valid)
        else $error("result shown before the back end could produce one");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_stall)
        else $error("input stalled right after reset");

endmodule

bind ones_complement_checksum_pseudo_header occ_chk u_occ_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_checksum (o_checksum)
);

`default_nettype wire
